>>> sv/sbot_pkg.sv
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared types and constants for the segment/box overlap test unit.
// ----------------------------------------------------------------------------
package sbot_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned WideW  = CoordW + 2;
  localparam int unsigned NAxes  = 3;
  localparam int unsigned NPlanes = 2;
  localparam int unsigned NOther = 2;

  typedef logic signed [CoordW-1:0]    coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;
  typedef logic signed [WideW-1:0]     wide_t;
  typedef logic [DiffW-1:0]            ext_t;
  typedef logic signed [2*WideW-1:0]   prod_a_t;
  typedef logic signed [2*DiffW-1:0]   prod_q_t;
  typedef logic signed [2*WideW:0]     sum_t;
  typedef logic [TolW-1:0]             tol_t;
  typedef logic [1:0]                  axis_t;

  typedef enum logic [2:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5,
    CFG_TOLERANCE = 3'd6
  } cfg_reg_t;

  localparam tol_t TolReset = tol_t'(1);

  // The o-th of the two axes other than k.
  function automatic axis_t other_axis(axis_t k, logic o);
    logic [2:0] t;
    t = {1'b0, k} + 3'd1 + {2'b00, o};
    return (t >= 3'd3) ? axis_t'(t - 3'd3) : axis_t'(t);
  endfunction

endpackage

>>> sv/sbot_ifs.sv
// ----------------------------------------------------------------------------
// sbot_in_if / sbot_out_if
// Valid/ready channels for segment items and hit results.
// ----------------------------------------------------------------------------
interface sbot_in_if;
  logic            valid;
  logic            ready;
  sbot_pkg::coord_t start_x;
  sbot_pkg::coord_t start_y;
  sbot_pkg::coord_t start_z;
  sbot_pkg::coord_t end_x;
  sbot_pkg::coord_t end_y;
  sbot_pkg::coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface sbot_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> sv/segment_box_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// segment_box_overlap_test_unit
// Segment versus axis-aligned box touch test, Q16.16, exact compares.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_wdata write the box bounds and the tolerance; write
//   them only while no item is in flight.
//   in_seg carries one segment item (start and end point) per valid/ready
//   handshake; out_res returns one hit bit per item, in order.
//   Throughput: one item per cycle while the skid entry is empty. An item
//   passes through the input register, difference stage, magnitude stage,
//   multiplier stage and output register before its result is presented.
//   The 34x34 and 33x33 cross-multiplications of the face test set the stage split;
//   each product is registered before the final add/compare.
//   A two-entry output (register plus skid) decouples the sides: in_seg.ready
//   depends only on the skid entry, so items keep flowing while a result
//   waits, and a stall on out_res freezes the pipe without loss.
//   Synchronous reset (rst_n low) empties the pipe and sets the box to zero
//   and the tolerance to one LSB.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [sbot_pkg::CoordW-1:0]      cfg_wdata,
  sbot_in_if.sink                          in_seg,
  sbot_out_if.source                       out_res
);

  // configuration
  sbot_pkg::coord_t bmin_r [sbot_pkg::NAxes];
  sbot_pkg::coord_t bmax_r [sbot_pkg::NAxes];
  sbot_pkg::tol_t   tol_r;
  sbot_pkg::diff_t  lo_r   [sbot_pkg::NAxes];
  sbot_pkg::diff_t  hi_r   [sbot_pkg::NAxes];

  // pipeline control
  logic en;
  logic v0_r, v1_r, v2_r, v3_r;
  logic o_v_r, o_v_nxt, o_hit_r, o_hit_nxt;
  logic sk_v_r, sk_v_nxt, sk_hit_r, sk_hit_nxt;
  logic take;

  // stage 0
  sbot_pkg::coord_t s0_r [sbot_pkg::NAxes];
  sbot_pkg::coord_t e0_r [sbot_pkg::NAxes];

  // stage 1
  sbot_pkg::diff_t d1_nxt   [sbot_pkg::NAxes];
  sbot_pkg::diff_t d1_r     [sbot_pkg::NAxes];
  sbot_pkg::diff_t num1_nxt [sbot_pkg::NAxes][sbot_pkg::NPlanes];
  sbot_pkg::diff_t num1_r   [sbot_pkg::NAxes][sbot_pkg::NPlanes];
  sbot_pkg::wide_t a1_nxt   [sbot_pkg::NAxes];
  sbot_pkg::wide_t a1_r     [sbot_pkg::NAxes];
  sbot_pkg::wide_t b1_nxt   [sbot_pkg::NAxes];
  sbot_pkg::wide_t b1_r     [sbot_pkg::NAxes];
  logic            ins1_nxt, ins1_r;

  // stage 2
  sbot_pkg::ext_t  dd2_nxt [sbot_pkg::NAxes];
  sbot_pkg::ext_t  dd2_r   [sbot_pkg::NAxes];
  sbot_pkg::diff_t n2_nxt  [sbot_pkg::NAxes][sbot_pkg::NPlanes];
  sbot_pkg::diff_t n2_r    [sbot_pkg::NAxes][sbot_pkg::NPlanes];
  sbot_pkg::diff_t d2_r    [sbot_pkg::NAxes];
  sbot_pkg::wide_t a2_r    [sbot_pkg::NAxes];
  sbot_pkg::wide_t b2_r    [sbot_pkg::NAxes];
  logic            ins2_r;

  // stage 3
  sbot_pkg::prod_a_t pa3_nxt [sbot_pkg::NAxes][sbot_pkg::NOther];
  sbot_pkg::prod_a_t pa3_r   [sbot_pkg::NAxes][sbot_pkg::NOther];
  sbot_pkg::prod_a_t pb3_nxt [sbot_pkg::NAxes][sbot_pkg::NOther];
  sbot_pkg::prod_a_t pb3_r   [sbot_pkg::NAxes][sbot_pkg::NOther];
  sbot_pkg::prod_q_t q3_nxt  [sbot_pkg::NAxes][sbot_pkg::NPlanes][sbot_pkg::NOther];
  sbot_pkg::prod_q_t q3_r    [sbot_pkg::NAxes][sbot_pkg::NPlanes][sbot_pkg::NOther];
  logic              pv3_nxt [sbot_pkg::NAxes][sbot_pkg::NPlanes];
  logic              pv3_r   [sbot_pkg::NAxes][sbot_pkg::NPlanes];
  logic              act3_nxt [sbot_pkg::NAxes];
  logic              act3_r   [sbot_pkg::NAxes];
  logic              ins3_r;

  // stage 4
  logic hit_c;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < sbot_pkg::NAxes; k++) begin
        bmin_r[k] <= '0;
        bmax_r[k] <= '0;
      end
      tol_r <= sbot_pkg::TolReset;
    end else if (cfg_we) begin
      case (sbot_pkg::cfg_reg_t'(cfg_index))
        sbot_pkg::CFG_BOX_MIN_X: bmin_r[0] <= cfg_wdata;
        sbot_pkg::CFG_BOX_MIN_Y: bmin_r[1] <= cfg_wdata;
        sbot_pkg::CFG_BOX_MIN_Z: bmin_r[2] <= cfg_wdata;
        sbot_pkg::CFG_BOX_MAX_X: bmax_r[0] <= cfg_wdata;
        sbot_pkg::CFG_BOX_MAX_Y: bmax_r[1] <= cfg_wdata;
        sbot_pkg::CFG_BOX_MAX_Z: bmax_r[2] <= cfg_wdata;
        sbot_pkg::CFG_TOLERANCE: tol_r <= cfg_wdata[sbot_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  // tolerance-widened face bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < sbot_pkg::NAxes; k++) begin
        lo_r[k] <= -sbot_pkg::diff_t'(sbot_pkg::TolReset);
        hi_r[k] <= sbot_pkg::diff_t'(sbot_pkg::TolReset);
      end
    end else begin
      for (int k = 0; k < sbot_pkg::NAxes; k++) begin
        lo_r[k] <= sbot_pkg::diff_t'(bmin_r[k]) - sbot_pkg::diff_t'(tol_r);
        hi_r[k] <= sbot_pkg::diff_t'(bmax_r[k]) + sbot_pkg::diff_t'(tol_r);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and valid bits
  // --------------------------------------------------------------------------
  assign en           = !sk_v_r;
  assign in_seg.ready = en;
  assign take         = o_v_r && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_seg.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: capture the item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r[0] <= in_seg.start_x;
      s0_r[1] <= in_seg.start_y;
      s0_r[2] <= in_seg.start_z;
      e0_r[0] <= in_seg.end_x;
      e0_r[1] <= in_seg.end_y;
      e0_r[2] <= in_seg.end_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: differences and endpoint containment
  // --------------------------------------------------------------------------
  always_comb begin
    logic in_s, in_e;
    in_s = 1'b1;
    in_e = 1'b1;
    for (int k = 0; k < sbot_pkg::NAxes; k++) begin
      d1_nxt[k] = sbot_pkg::diff_t'(e0_r[k]) - sbot_pkg::diff_t'(s0_r[k]);
      num1_nxt[k][0] = sbot_pkg::diff_t'(bmin_r[k]) - sbot_pkg::diff_t'(s0_r[k]);
      num1_nxt[k][1] = sbot_pkg::diff_t'(bmax_r[k]) - sbot_pkg::diff_t'(s0_r[k]);
      a1_nxt[k] = sbot_pkg::wide_t'(s0_r[k]) - sbot_pkg::wide_t'(lo_r[k]);
      b1_nxt[k] = sbot_pkg::wide_t'(hi_r[k]) - sbot_pkg::wide_t'(s0_r[k]);
      if (s0_r[k] < bmin_r[k] || s0_r[k] > bmax_r[k]) begin
        in_s = 1'b0;
      end
      if (e0_r[k] < bmin_r[k] || e0_r[k] > bmax_r[k]) begin
        in_e = 1'b0;
      end
    end
    ins1_nxt = in_s || in_e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= d1_nxt;
      num1_r <= num1_nxt;
      a1_r   <= a1_nxt;
      b1_r   <= b1_nxt;
      ins1_r <= ins1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: axis extent and direction-normalized plane numerators
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < sbot_pkg::NAxes; k++) begin
      dd2_nxt[k] = sbot_pkg::ext_t'(d1_r[k][sbot_pkg::DiffW-1] ? -d1_r[k] : d1_r[k]);
      for (int p = 0; p < sbot_pkg::NPlanes; p++) begin
        n2_nxt[k][p] = d1_r[k][sbot_pkg::DiffW-1] ? -num1_r[k][p] : num1_r[k][p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd2_r  <= dd2_nxt;
      n2_r   <= n2_nxt;
      d2_r   <= d1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      ins2_r <= ins1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cross products, t range and extent checks
  // --------------------------------------------------------------------------
  always_comb begin
    sbot_pkg::axis_t j;
    sbot_pkg::wide_t dds;
    for (int k = 0; k < sbot_pkg::NAxes; k++) begin
      dds = sbot_pkg::wide_t'(dd2_r[k]);
      act3_nxt[k] = dd2_r[k] > sbot_pkg::ext_t'(tol_r);
      for (int p = 0; p < sbot_pkg::NPlanes; p++) begin
        pv3_nxt[k][p] = !n2_r[k][p][sbot_pkg::DiffW-1] &&
                        (sbot_pkg::ext_t'(n2_r[k][p]) <= dd2_r[k]);
      end
      for (int o = 0; o < sbot_pkg::NOther; o++) begin
        j = sbot_pkg::other_axis(sbot_pkg::axis_t'(k), o[0]);
        pa3_nxt[k][o] = a2_r[j] * dds;
        pb3_nxt[k][o] = b2_r[j] * dds;
        for (int p = 0; p < sbot_pkg::NPlanes; p++) begin
          q3_nxt[k][p][o] = d2_r[j] * n2_r[k][p];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa3_r  <= pa3_nxt;
      pb3_r  <= pb3_nxt;
      q3_r   <= q3_nxt;
      pv3_r  <= pv3_nxt;
      act3_r <= act3_nxt;
      ins3_r <= ins2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: face bound compares and hit reduction
  // --------------------------------------------------------------------------
  always_comb begin
    sbot_pkg::sum_t lo_sum, hi_sum;
    logic ok;
    hit_c = ins3_r;
    for (int k = 0; k < sbot_pkg::NAxes; k++) begin
      for (int p = 0; p < sbot_pkg::NPlanes; p++) begin
        ok = act3_r[k] && pv3_r[k][p];
        for (int o = 0; o < sbot_pkg::NOther; o++) begin
          lo_sum = sbot_pkg::sum_t'(pa3_r[k][o]) + sbot_pkg::sum_t'(q3_r[k][p][o]);
          hi_sum = sbot_pkg::sum_t'(pb3_r[k][o]) - sbot_pkg::sum_t'(q3_r[k][p][o]);
          if (lo_sum[2*sbot_pkg::WideW] || hi_sum[2*sbot_pkg::WideW]) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          hit_c = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid entry
  // --------------------------------------------------------------------------
  always_comb begin
    o_v_nxt    = o_v_r;
    o_hit_nxt  = o_hit_r;
    sk_v_nxt   = sk_v_r;
    sk_hit_nxt = sk_hit_r;
    if (!sk_v_r) begin
      if (!o_v_r || take) begin
        o_v_nxt   = v3_r;
        o_hit_nxt = hit_c;
      end else if (v3_r) begin
        sk_v_nxt   = 1'b1;
        sk_hit_nxt = hit_c;
      end
    end else if (take) begin
      o_v_nxt   = 1'b1;
      o_hit_nxt = sk_hit_r;
      sk_v_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      o_v_r  <= o_v_nxt;
      sk_v_r <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_hit_r  <= o_hit_nxt;
    sk_hit_r <= sk_hit_nxt;
  end

  assign out_res.valid = o_v_r;
  assign out_res.hit   = o_hit_r;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> o_v_r)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r && out_res.ready |=> !sk_v_r && o_v_r && (o_hit_r == $past(sk_hit_r)))
    else $error("skid item not moved to output register");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !o_v_r && !sk_v_r && !v0_r && !v3_r)
    else $error("pipeline not empty after reset");
`endif

endmodule
